>>> design/conv1d_pkg.sv
// Shared types, constants and field widths of the 1-D convolution engine.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none
package conv1d_pkg;

  // Store dimensions
  localparam int MAX_IN_CH  = 16;
  localparam int MAX_OUT_CH = 16;
  localparam int MAX_IN_LEN = 256;
  localparam int MAX_KERNEL = 16;

  localparam int ICH_W  = (MAX_IN_CH  > 1) ? $clog2(MAX_IN_CH)  : 1;
  localparam int OCH_W  = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
  localparam int LEN_W  = (MAX_IN_LEN > 1) ? $clog2(MAX_IN_LEN) : 1;
  localparam int KER_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int SMP_AW = ICH_W + LEN_W;
  localparam int KRN_AW = OCH_W + ICH_W + KER_W;

  // Transaction field widths
  localparam int OPC_W  = 2;
  localparam int CHAN_W = 4;
  localparam int POS_W  = 10;
  localparam int VAL_W  = 16;
  localparam int ACC_W  = 40;
  localparam int STAT_W = 2;
  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_W = 15;

  // Register widths
  localparam int CH_CFG_W  = 5;
  localparam int LEN_CFG_W = 9;
  localparam int KER_CFG_W = 5;
  localparam int PAD_CFG_W = 10;
  localparam int STR_CFG_W = 9;

  // Index arithmetic widths
  localparam int SPOS_W = POS_W + STR_CFG_W;   // position times stride
  localparam int N_W    = 12;                  // signed data index
  localparam int DIVS_W = 10;                  // divisor (length or reflect period)

  // APB
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [OPC_W-1:0] {
    OP_SAMPLE  = 2'd0,
    OP_WEIGHT  = 2'd1,
    OP_BIAS    = 2'd2,
    OP_COMPUTE = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_CFG = 2'd1,
    ST_BAD_POS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PAD_ZERO = 2'd0,
    PAD_REPL = 2'd1,
    PAD_REFL = 2'd2,
    PAD_CIRC = 2'd3
  } pad_mode_e;

  typedef enum logic [2:0] {
    REG_IN_CH    = 3'd0,
    REG_OUT_CH   = 3'd1,
    REG_IN_LEN   = 3'd2,
    REG_KER_LEN  = 3'd3,
    REG_PAD      = 3'd4,
    REG_STRIDE   = 3'd5,
    REG_CEIL     = 3'd6,
    REG_PAD_MODE = 3'd7
  } reg_e;

  typedef struct packed {
    logic [CH_CFG_W-1:0]         in_channels;
    logic [CH_CFG_W-1:0]         out_channels;
    logic [LEN_CFG_W-1:0]        in_length;
    logic [KER_CFG_W-1:0]        kernel_length;
    logic signed [PAD_CFG_W-1:0] pad_amount;
    logic [STR_CFG_W-1:0]        stride;
    logic                        ceil_mode;
    pad_mode_e                   pad_mode;
  } cfg_t;

endpackage
`default_nettype wire

>>> design/conv1d_cfg.sv
// Configuration register file behind an APB-style slave port.
// Depends on conv1d_pkg for register indexes and the cfg_t bundle.
`default_nettype none
module conv1d_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [conv1d_pkg::PADDR_W-1:0]     paddr,
  input  logic [conv1d_pkg::PDATA_W-1:0]     pwdata,
  output logic [conv1d_pkg::PDATA_W-1:0]     prdata,
  output logic                               pready,
  output conv1d_pkg::cfg_t                   cfg_o
);

  conv1d_pkg::cfg_t cfg_q, cfg_d;
  conv1d_pkg::reg_e reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = conv1d_pkg::reg_e'(paddr[conv1d_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  // Decode write transaction
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        conv1d_pkg::REG_IN_CH:    cfg_d.in_channels   = pwdata[conv1d_pkg::CH_CFG_W-1:0];
        conv1d_pkg::REG_OUT_CH:   cfg_d.out_channels  = pwdata[conv1d_pkg::CH_CFG_W-1:0];
        conv1d_pkg::REG_IN_LEN:   cfg_d.in_length     = pwdata[conv1d_pkg::LEN_CFG_W-1:0];
        conv1d_pkg::REG_KER_LEN:  cfg_d.kernel_length = pwdata[conv1d_pkg::KER_CFG_W-1:0];
        conv1d_pkg::REG_PAD:      cfg_d.pad_amount    = $signed(pwdata[conv1d_pkg::PAD_CFG_W-1:0]);
        conv1d_pkg::REG_STRIDE:   cfg_d.stride        = pwdata[conv1d_pkg::STR_CFG_W-1:0];
        conv1d_pkg::REG_CEIL:     cfg_d.ceil_mode     = pwdata[0];
        conv1d_pkg::REG_PAD_MODE: cfg_d.pad_mode      = conv1d_pkg::pad_mode_e'(pwdata[1:0]);
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  // Return register contents on read
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      conv1d_pkg::REG_IN_CH:    prdata = conv1d_pkg::PDATA_W'(cfg_q.in_channels);
      conv1d_pkg::REG_OUT_CH:   prdata = conv1d_pkg::PDATA_W'(cfg_q.out_channels);
      conv1d_pkg::REG_IN_LEN:   prdata = conv1d_pkg::PDATA_W'(cfg_q.in_length);
      conv1d_pkg::REG_KER_LEN:  prdata = conv1d_pkg::PDATA_W'(cfg_q.kernel_length);
      conv1d_pkg::REG_PAD:      prdata = conv1d_pkg::PDATA_W'($unsigned(cfg_q.pad_amount));
      conv1d_pkg::REG_STRIDE:   prdata = conv1d_pkg::PDATA_W'(cfg_q.stride);
      conv1d_pkg::REG_CEIL:     prdata = conv1d_pkg::PDATA_W'(cfg_q.ceil_mode);
      conv1d_pkg::REG_PAD_MODE: prdata = conv1d_pkg::PDATA_W'(cfg_q.pad_mode);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_channels   <= conv1d_pkg::CH_CFG_W'(1);
      cfg_q.out_channels  <= conv1d_pkg::CH_CFG_W'(1);
      cfg_q.in_length     <= conv1d_pkg::LEN_CFG_W'(1);
      cfg_q.kernel_length <= conv1d_pkg::KER_CFG_W'(1);
      cfg_q.pad_amount    <= '0;
      cfg_q.stride        <= conv1d_pkg::STR_CFG_W'(1);
      cfg_q.ceil_mode     <= 1'b0;
      cfg_q.pad_mode      <= conv1d_pkg::PAD_ZERO;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

>>> design/conv1d_mem.sv
// Sample, kernel and bias stores with registered reads on the large stores.
// Depends on conv1d_pkg for store geometry.
`default_nettype none
module conv1d_mem (
  input  logic                                  clk_i,
  input  logic                                  smp_we_i,
  input  logic [conv1d_pkg::SMP_AW-1:0]         smp_waddr_i,
  input  logic [conv1d_pkg::SMP_AW-1:0]         smp_raddr_i,
  output logic signed [conv1d_pkg::VAL_W-1:0]   smp_rdata_o,
  input  logic                                  krn_we_i,
  input  logic [conv1d_pkg::KRN_AW-1:0]         krn_waddr_i,
  input  logic [conv1d_pkg::KRN_AW-1:0]         krn_raddr_i,
  output logic signed [conv1d_pkg::VAL_W-1:0]   krn_rdata_o,
  input  logic                                  bias_we_i,
  input  logic [conv1d_pkg::OCH_W-1:0]          bias_waddr_i,
  input  logic [conv1d_pkg::OCH_W-1:0]          bias_raddr_i,
  output logic signed [conv1d_pkg::VAL_W-1:0]   bias_rdata_o,
  input  logic signed [conv1d_pkg::VAL_W-1:0]   wdata_i
);

  localparam int SMP_DEPTH = conv1d_pkg::MAX_IN_CH * conv1d_pkg::MAX_IN_LEN;
  localparam int KRN_DEPTH = conv1d_pkg::MAX_OUT_CH * conv1d_pkg::MAX_IN_CH *
                             conv1d_pkg::MAX_KERNEL;

  logic signed [conv1d_pkg::VAL_W-1:0] smp_mem  [SMP_DEPTH];
  logic signed [conv1d_pkg::VAL_W-1:0] krn_mem  [KRN_DEPTH];
  logic signed [conv1d_pkg::VAL_W-1:0] bias_mem [conv1d_pkg::MAX_OUT_CH];

  // Sample store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (smp_we_i) begin
      smp_mem[smp_waddr_i] <= wdata_i;
    end
    smp_rdata_o <= smp_mem[smp_raddr_i];
  end

  // Kernel store
  always_ff @(posedge clk_i) begin
    if (krn_we_i) begin
      krn_mem[krn_waddr_i] <= wdata_i;
    end
    krn_rdata_o <= krn_mem[krn_raddr_i];
  end

  // Bias registers
  always_ff @(posedge clk_i) begin
    if (bias_we_i) begin
      bias_mem[bias_waddr_i] <= wdata_i;
    end
  end

  assign bias_rdata_o = bias_mem[bias_raddr_i];

endmodule
`default_nettype wire

>>> design/conv1d_mod.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on conv1d_pkg for operand widths.
`default_nettype none
module conv1d_mod (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [conv1d_pkg::N_W-1:0]      dividend_i,
  input  logic [conv1d_pkg::DIVS_W-1:0]   divisor_i,
  output logic                            done_o,
  output logic [conv1d_pkg::DIVS_W-1:0]   rem_o
);

  localparam int CNT_W = $clog2(conv1d_pkg::N_W);

  logic [conv1d_pkg::N_W-1:0]    dvd_q;
  logic [conv1d_pkg::DIVS_W-1:0] dvs_q, rem_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          busy_q, done_q;
  logic [conv1d_pkg::DIVS_W:0]   shifted;
  logic [conv1d_pkg::DIVS_W-1:0] rem_d;

  // Shift in next dividend bit, subtract when it fits
  always_comb begin
    shifted = {rem_q, dvd_q[conv1d_pkg::N_W-1]};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = conv1d_pkg::DIVS_W'(shifted - {1'b0, dvs_q});
    end else begin
      rem_d = conv1d_pkg::DIVS_W'(shifted);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(conv1d_pkg::N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[conv1d_pkg::N_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

>>> design/conv1d_mac.sv
// Shared multiply-accumulate unit: registered product, 40-bit saturating sum.
// Depends on conv1d_pkg for data widths.
`default_nettype none
module conv1d_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clr_i,
  input  logic signed [conv1d_pkg::ACC_W-1:0] clr_val_i,
  input  logic                                v_i,
  input  logic signed [conv1d_pkg::VAL_W-1:0] x_i,
  input  logic signed [conv1d_pkg::VAL_W-1:0] w_i,
  output logic                                busy_o,
  output logic signed [conv1d_pkg::ACC_W-1:0] acc_o
);

  localparam logic signed [conv1d_pkg::ACC_W-1:0] ACC_MAX =
    {1'b0, {(conv1d_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [conv1d_pkg::ACC_W-1:0] ACC_MIN =
    {1'b1, {(conv1d_pkg::ACC_W-1){1'b0}}};

  logic signed [conv1d_pkg::PROD_W-1:0] prod_q;
  logic                                 pv_q;
  logic signed [conv1d_pkg::ACC_W-1:0]  acc_q, sat;
  logic signed [conv1d_pkg::ACC_W:0]    sum;

  // Add with one guard bit, clamp on overflow
  always_comb begin
    sum = $signed({acc_q[conv1d_pkg::ACC_W-1], acc_q}) +
          (conv1d_pkg::ACC_W+1)'(prod_q);
    if (sum[conv1d_pkg::ACC_W] != sum[conv1d_pkg::ACC_W-1]) begin
      sat = sum[conv1d_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat = sum[conv1d_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= x_i * w_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      pv_q <= v_i && !clr_i;
      if (clr_i) begin
        acc_q <= clr_val_i;
      end else if (pv_q) begin
        acc_q <= sat;
      end
    end
  end

  assign busy_o = pv_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

>>> design/conv1d_padded_strided.sv
// Top level of the 1-D convolution engine: sequencer, index walk, output register.
// Depends on conv1d_pkg, conv1d_cfg, conv1d_mem, conv1d_mod and conv1d_mac.
//
// Load transactions (sample, weight, bias) are stored when accepted and in
// bounds. A compute transaction runs a setup check, then the remainder unit
// for reflect or circular padding, then in_channels * kernel_length taps of
// multiply-accumulate (one tap per cycle through the single shared MAC, at
// most 256), then drains the memory-read and product stages; the MAC tap
// loop sets the rate. Invalid configurations and out-of-range channels or
// positions return after setup with a status and a zero value. in_stall_o
// stays high while a compute runs. A finished result sits in an output
// register until taken; loads are accepted meanwhile.
`default_nettype none
module conv1d_padded_strided (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [conv1d_pkg::PADDR_W-1:0]      paddr,
  input  logic [conv1d_pkg::PDATA_W-1:0]      pwdata,
  output logic [conv1d_pkg::PDATA_W-1:0]      prdata,
  output logic                                pready,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [conv1d_pkg::OPC_W-1:0]        opcode_i,
  input  logic [conv1d_pkg::CHAN_W-1:0]       out_chan_i,
  input  logic [conv1d_pkg::CHAN_W-1:0]       in_chan_i,
  input  logic [conv1d_pkg::POS_W-1:0]        position_i,
  input  logic signed [conv1d_pkg::VAL_W-1:0] value_i,
  // Result channel
  output logic                                result_valid_o,
  input  logic                                result_stall_i,
  output logic [conv1d_pkg::CHAN_W-1:0]       result_chan_o,
  output logic [conv1d_pkg::POS_W-1:0]        result_pos_o,
  output logic signed [conv1d_pkg::ACC_W-1:0] result_value_o,
  output logic [conv1d_pkg::STAT_W-1:0]       status_o
);

  localparam int N_W    = conv1d_pkg::N_W;
  localparam int DIVS_W = conv1d_pkg::DIVS_W;
  localparam int LCW    = conv1d_pkg::LEN_CFG_W;
  localparam int CW     = conv1d_pkg::CH_CFG_W;
  localparam int KW     = conv1d_pkg::KER_CFG_W;
  localparam int SW     = conv1d_pkg::SPOS_W;
  localparam int BW     = SW + 2;   // signed base index before narrowing

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_RUN   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  conv1d_pkg::cfg_t    cfg;
  conv1d_pkg::opcode_e opc;
  logic                in_acc;

  // Transaction and walk registers
  logic [conv1d_pkg::CHAN_W-1:0] oc_q;
  logic [conv1d_pkg::POS_W-1:0]  pos_q;
  logic [SW-1:0]                 spos_q;
  conv1d_pkg::status_e           stat_q, stat_d;
  logic signed [N_W-1:0]         n_base_q, n_q;
  logic [DIVS_W-1:0]             r_base_q, r_q;
  logic [CW-1:0]                 ch_q;
  logic [KW-1:0]                 k_q;
  logic                          v1_q;

  // Output register
  logic                          out_v_q;
  logic [conv1d_pkg::CHAN_W-1:0] out_chan_q;
  logic [conv1d_pkg::POS_W-1:0]  out_pos_q;
  logic signed [conv1d_pkg::ACC_W-1:0] out_val_q;
  conv1d_pkg::status_e           out_stat_q;
  logic                          out_free;

  // Config-derived values
  logic signed [N_W-1:0]   li_s, lk_s, pad_s, t_s, d_s;
  logic [DIVS_W-1:0]       li_w, period;
  logic                    cfg_bad, pos_ok, use_div, refl_short;
  logic signed [BW-1:0]    base_full;
  logic signed [N_W-1:0]   base_n;
  logic [N_W-1:0]          div_dvd;
  logic [DIVS_W-1:0]       div_dvs, div_rem;
  logic                    div_start, div_done;

  // Tap mapping
  logic [DIVS_W-1:0]       m_idx, r_next, r_lim;
  logic                    tap_skip, last_tap, last_ch, issue;

  // Memory and MAC
  logic                    smp_we, krn_we, bias_we;
  logic [conv1d_pkg::SMP_AW-1:0] smp_waddr, smp_raddr;
  logic [conv1d_pkg::KRN_AW-1:0] krn_waddr, krn_raddr;
  logic signed [conv1d_pkg::VAL_W-1:0] smp_rdata, krn_rdata, bias_rdata;
  logic signed [conv1d_pkg::ACC_W-1:0] acc, bias_ext;
  logic                    mac_clr, mac_busy;

  conv1d_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign opc        = conv1d_pkg::opcode_e'(opcode_i);

  // Load write enables with store bound checks
  always_comb begin
    smp_we  = 1'b0;
    krn_we  = 1'b0;
    bias_we = 1'b0;
    if (in_acc) begin
      unique case (opc)
        conv1d_pkg::OP_SAMPLE:
          smp_we = (32'(in_chan_i) < conv1d_pkg::MAX_IN_CH) &&
                   (32'(position_i) < conv1d_pkg::MAX_IN_LEN);
        conv1d_pkg::OP_WEIGHT:
          krn_we = (32'(out_chan_i) < conv1d_pkg::MAX_OUT_CH) &&
                   (32'(in_chan_i) < conv1d_pkg::MAX_IN_CH) &&
                   (32'(position_i) < conv1d_pkg::MAX_KERNEL);
        conv1d_pkg::OP_BIAS:
          bias_we = (32'(out_chan_i) < conv1d_pkg::MAX_OUT_CH);
        default: ;
      endcase
    end
  end

  assign smp_waddr = (conv1d_pkg::SMP_AW'(in_chan_i) << conv1d_pkg::LEN_W) |
                     conv1d_pkg::SMP_AW'(position_i);
  assign krn_waddr = (conv1d_pkg::KRN_AW'(out_chan_i) <<
                      (conv1d_pkg::ICH_W + conv1d_pkg::KER_W)) |
                     (conv1d_pkg::KRN_AW'(in_chan_i) << conv1d_pkg::KER_W) |
                     conv1d_pkg::KRN_AW'(position_i);

  // Output length check and validity of the configuration
  always_comb begin
    li_s   = N_W'(cfg.in_length);
    lk_s   = N_W'(cfg.kernel_length);
    pad_s  = N_W'(cfg.pad_amount);
    t_s    = li_s + (pad_s <<< 1);
    d_s    = t_s - lk_s;
    li_w   = DIVS_W'(cfg.in_length);
    period = DIVS_W'({cfg.in_length, 1'b0}) - DIVS_W'(2);
    cfg_bad =
      (cfg.in_channels == '0) || (32'(cfg.in_channels) > conv1d_pkg::MAX_IN_CH) ||
      (cfg.out_channels == '0) || (32'(cfg.out_channels) > conv1d_pkg::MAX_OUT_CH) ||
      (cfg.in_length == '0) || (32'(cfg.in_length) > conv1d_pkg::MAX_IN_LEN) ||
      (cfg.kernel_length == '0) || (32'(cfg.kernel_length) > conv1d_pkg::MAX_KERNEL) ||
      (cfg.stride == '0) || (lk_s > li_s) || (pad_s <= -li_s) ||
      ((cfg.pad_mode != conv1d_pkg::PAD_ZERO) && (pad_s > li_s)) ||
      ((cfg.pad_mode == conv1d_pkg::PAD_REFL) && (pad_s >= li_s)) ||
      (t_s < lk_s);
    // floor: pos*stride <= D; ceil: pos == 0 or (pos-1)*stride < D
    if (cfg.ceil_mode) begin
      pos_ok = (pos_q == '0) || ((spos_q - SW'(cfg.stride)) < SW'($unsigned(d_s)));
    end else begin
      pos_ok = spos_q <= SW'($unsigned(d_s));
    end
    if (cfg_bad) begin
      stat_d = conv1d_pkg::ST_BAD_CFG;
    end else if ((oc_q >= conv1d_pkg::CHAN_W'(cfg.out_channels)) && (cfg.out_channels <= CW'(15)))
    begin
      stat_d = conv1d_pkg::ST_BAD_POS;
    end else if (!pos_ok) begin
      stat_d = conv1d_pkg::ST_BAD_POS;
    end else begin
      stat_d = conv1d_pkg::ST_OK;
    end
    base_full  = $signed({2'b00, spos_q}) - BW'(cfg.pad_amount);
    base_n     = N_W'(base_full);
    refl_short = (cfg.in_length < LCW'(2));
    use_div    = (cfg.pad_mode == conv1d_pkg::PAD_CIRC) ||
                 ((cfg.pad_mode == conv1d_pkg::PAD_REFL) && !refl_short);
    // Shift the base into range; it is never below minus one period
    if (cfg.pad_mode == conv1d_pkg::PAD_CIRC) begin
      div_dvd = $unsigned(base_n + N_W'(li_w));
      div_dvs = li_w;
    end else begin
      div_dvd = $unsigned(base_n + N_W'(period));
      div_dvs = period;
    end
  end

  assign div_start = (state_q == S_CHECK) && (stat_d == conv1d_pkg::ST_OK) && use_div;

  conv1d_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Map the current tap to a stored sample index
  always_comb begin
    tap_skip = 1'b0;
    m_idx    = '0;
    r_lim    = (cfg.pad_mode == conv1d_pkg::PAD_CIRC) ? li_w : period;
    r_next   = (r_q + DIVS_W'(1) == r_lim) ? '0 : r_q + DIVS_W'(1);
    unique case (cfg.pad_mode)
      conv1d_pkg::PAD_ZERO: begin
        tap_skip = (n_q < 0) || (n_q >= li_s);
        m_idx    = DIVS_W'($unsigned(n_q));
      end
      conv1d_pkg::PAD_REPL: begin
        if (n_q < 0) begin
          m_idx = '0;
        end else if (n_q >= li_s) begin
          m_idx = li_w - DIVS_W'(1);
        end else begin
          m_idx = DIVS_W'($unsigned(n_q));
        end
      end
      conv1d_pkg::PAD_REFL: begin
        if (refl_short) begin
          m_idx = '0;
        end else if (r_q >= li_w) begin
          m_idx = period - r_q;
        end else begin
          m_idx = r_q;
        end
      end
      default: m_idx = r_q;
    endcase
  end

  assign last_tap = (KW'(k_q + KW'(1)) == cfg.kernel_length);
  assign last_ch  = (CW'(ch_q + CW'(1)) == cfg.in_channels);
  assign issue    = (state_q == S_RUN);

  assign smp_raddr = (conv1d_pkg::SMP_AW'(ch_q) << conv1d_pkg::LEN_W) |
                     conv1d_pkg::SMP_AW'(m_idx);
  assign krn_raddr = (conv1d_pkg::KRN_AW'(oc_q) <<
                      (conv1d_pkg::ICH_W + conv1d_pkg::KER_W)) |
                     (conv1d_pkg::KRN_AW'(ch_q) << conv1d_pkg::KER_W) |
                     conv1d_pkg::KRN_AW'(k_q);

  conv1d_mem u_mem (
    .clk_i        (clk_i),
    .smp_we_i     (smp_we),
    .smp_waddr_i  (smp_waddr),
    .smp_raddr_i  (smp_raddr),
    .smp_rdata_o  (smp_rdata),
    .krn_we_i     (krn_we),
    .krn_waddr_i  (krn_waddr),
    .krn_raddr_i  (krn_raddr),
    .krn_rdata_o  (krn_rdata),
    .bias_we_i    (bias_we),
    .bias_waddr_i (conv1d_pkg::OCH_W'(out_chan_i)),
    .bias_raddr_i (conv1d_pkg::OCH_W'(oc_q)),
    .bias_rdata_o (bias_rdata),
    .wdata_i      (value_i)
  );

  // Bias in Q10.30
  assign bias_ext = conv1d_pkg::ACC_W'(bias_rdata) <<< conv1d_pkg::FRAC_W;
  assign mac_clr  = (state_q == S_CHECK);

  conv1d_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (mac_clr),
    .clr_val_i (bias_ext),
    .v_i       (v1_q),
    .x_i       (smp_rdata),
    .w_i       (krn_rdata),
    .busy_o    (mac_busy),
    .acc_o     (acc)
  );

  assign out_free = !out_v_q || !result_stall_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && (opc == conv1d_pkg::OP_COMPUTE)) state_d = S_CHECK;
      S_CHECK: begin
        if (stat_d != conv1d_pkg::ST_OK) begin
          state_d = S_DONE;
        end else if (use_div) begin
          state_d = S_DIV;
        end else begin
          state_d = S_RUN;
        end
      end
      S_DIV:   if (div_done) state_d = S_RUN;
      S_RUN:   if (last_tap && last_ch) state_d = S_DRAIN;
      S_DRAIN: if (!v1_q && !mac_busy) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      v1_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue && !tap_skip;
      if ((state_q == S_DONE) && out_free) begin
        out_v_q <= 1'b1;
      end else if (!result_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Capture the compute transaction and walk channels and taps
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      oc_q   <= out_chan_i;
      pos_q  <= position_i;
      spos_q <= position_i * cfg.stride;
    end
    if (state_q == S_CHECK) begin
      stat_q   <= stat_d;
      n_base_q <= base_n;
      n_q      <= base_n;
      r_base_q <= '0;
      r_q      <= '0;
      ch_q     <= '0;
      k_q      <= '0;
    end
    if ((state_q == S_DIV) && div_done) begin
      r_base_q <= div_rem;
      r_q      <= div_rem;
    end
    if (state_q == S_RUN) begin
      if (last_tap) begin
        k_q  <= '0;
        n_q  <= n_base_q;
        r_q  <= r_base_q;
        ch_q <= ch_q + CW'(1);
      end else begin
        k_q <= k_q + KW'(1);
        n_q <= n_q + N_W'(1);
        r_q <= r_next;
      end
    end
    if ((state_q == S_DONE) && out_free) begin
      out_chan_q <= oc_q;
      out_pos_q  <= pos_q;
      out_stat_q <= stat_q;
      out_val_q  <= (stat_q == conv1d_pkg::ST_OK) ? acc : '0;
    end
  end

  assign result_valid_o = out_v_q;
  assign result_chan_o  = out_chan_q;
  assign result_pos_o   = out_pos_q;
  assign result_value_o = out_val_q;
  assign status_o       = out_stat_q;

endmodule
`default_nettype wire

>>> design/conv1d_chk.sv
// Port-level checker for the convolution engine, bound to the top level.
// Depends on conv1d_pkg for opcode and status codes.
`default_nettype none
module conv1d_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [conv1d_pkg::OPC_W-1:0]        opcode_i,
  input logic                                result_valid_o,
  input logic                                result_stall_i,
  input logic signed [conv1d_pkg::ACC_W-1:0] result_value_o,
  input logic [conv1d_pkg::STAT_W-1:0]       status_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_stall_i |=> result_valid_o && $stable(result_value_o))
    else $error("stalled result changed");

  // Flagged results carry a zero sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != conv1d_pkg::ST_OK) |-> result_value_o == '0)
    else $error("flagged result with nonzero value");

  // Status stays within its defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> status_o != 2'd3)
    else $error("undefined status code");

  // Block further input while a compute runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == conv1d_pkg::OP_COMPUTE) |=> in_stall_o)
    else $error("input taken during compute");

endmodule

bind conv1d_padded_strided conv1d_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .result_stall_i (result_stall_i),
  .result_value_o (result_value_o),
  .status_o       (status_o)
);
`default_nettype wire
